// File: rtl/rst_pkg.sv
// Shared types, codes and command/status structures of the ride session tracker.
package rst_pkg;

    localparam int unsigned DivSteps = 14;

    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_MIN_AVG  = 1'b1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd500;
    localparam logic [13:0] MIN_AVG_RESET  = 14'd150;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_NEW    = 3'd1,
        EV_PAUSE  = 3'd2,
        EV_RESUME = 3'd3,
        EV_STOP   = 3'd4
    } t_event;

    typedef struct packed {
        logic capture;
        logic touch;
        logic sample;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: rtl/rst_ctrl.sv
// Sequencer that steps one word through touch, sample, divide and result load.
module rst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rst_pkg::t_status i_status,
    output logic             o_in_stall,
    output rst_pkg::t_cmd    o_cmd
);
    import rst_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TOUCH  = 6'b000010,
        ST_SAMPLE = 6'b000100,
        ST_PREP   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_TOUCH;
                end
            end
            ST_TOUCH: begin
                o_cmd.touch = 1'b1;
                n_state     = ST_SAMPLE;
            end
            ST_SAMPLE: begin
                o_cmd.sample = 1'b1;
                n_state      = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/rst_datapath.sv
// Ride state, statistics, mean divider and output register of the ride session tracker.
module rst_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rst_pkg::t_cmd i_cmd,
    output rst_pkg::t_status o_status,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic [31:0]   i_now_ms,
    input  logic          i_touch_present,
    input  logic          i_hit_start,
    input  logic          i_hit_continue,
    input  logic          i_hit_stop,
    input  logic          i_sample_valid,
    input  logic [15:0]   i_distance_mm,
    input  logic [13:0]   i_speed_centi,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [1:0]    o_ride_state,
    output logic [2:0]    o_event_res,
    output logic [31:0]   o_total_distance_mm,
    output logic [31:0]   o_ride_ticks,
    output logic [13:0]   o_average_speed,
    output logic [13:0]   o_peak_speed
);
    import rst_pkg::*;

    localparam int unsigned StepW = $clog2(DivSteps);

    logic [15:0] r_debounce;
    logic [13:0] r_min_avg;

    logic [31:0] r_now;
    logic        r_touch;
    logic        r_hs;
    logic        r_hc;
    logic        r_hp;
    logic        r_sv;
    logic [15:0] r_dist;
    logic [13:0] r_speed;

    t_mode       r_mode;
    t_event      r_event;
    logic [31:0] r_last;
    logic        r_consumed;
    logic [31:0] r_dist_tot;
    logic [31:0] r_ticks;
    logic [37:0] r_sum;
    logic [23:0] r_count;
    logic [13:0] r_peak;

    logic [23:0]      r_rem;
    logic [13:0]      r_low;
    logic [13:0]      r_quo;
    logic [StepW-1:0] r_dcnt;

    logic [31:0] r_o_dist;
    logic [31:0] r_o_ticks;
    logic [13:0] r_o_avg;
    logic [13:0] r_o_peak;
    logic [1:0]  r_o_state;
    logic [2:0]  r_o_event;
    logic        r_out_valid;

    logic [31:0] w_gap;
    logic        w_elapsed;
    t_mode       w_mode;
    t_event      w_event;
    logic [32:0] w_dsum;
    logic [24:0] w_trial;
    logic [24:0] w_diff;
    logic        w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_min_avg  <= MIN_AVG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_MIN_AVG:  r_min_avg  <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now   <= i_now_ms;
            r_touch <= i_touch_present;
            r_hs    <= i_hit_start;
            r_hc    <= i_hit_continue;
            r_hp    <= i_hit_stop;
            r_sv    <= i_sample_valid;
            r_dist  <= i_distance_mm;
            r_speed <= i_speed_centi;
        end
    end

    assign w_gap     = r_now - r_last;
    assign w_elapsed = w_gap > {16'd0, r_debounce};

    always_comb begin
        w_mode  = r_mode;
        w_event = EV_NONE;
        if (w_elapsed) begin
            case (r_mode)
                MODE_PAUSED: begin
                    if (r_hc) begin
                        w_mode  = MODE_RUNNING;
                        w_event = EV_RESUME;
                    end else if (r_hp) begin
                        w_mode  = MODE_STOPPED;
                        w_event = EV_STOP;
                    end
                end
                MODE_STOPPED: begin
                    if (r_hs) begin
                        w_mode  = MODE_RUNNING;
                        w_event = EV_NEW;
                    end
                end
                MODE_RUNNING: begin
                    if (r_hs) begin
                        w_mode  = MODE_PAUSED;
                        w_event = EV_PAUSE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_dsum = {1'b0, r_dist_tot} + {17'd0, r_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_STOPPED;
            r_event    <= EV_NONE;
            r_last     <= '0;
            r_consumed <= 1'b0;
            r_dist_tot <= '0;
            r_ticks    <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_peak     <= '0;
        end else if (i_cmd.touch) begin
            r_event <= (r_touch && !r_consumed) ? w_event : EV_NONE;
            if (r_touch) begin
                r_consumed <= !r_consumed;
                if (!r_consumed) begin
                    r_mode <= w_mode;
                    if (w_event != EV_NONE) begin
                        r_last <= r_now;
                    end
                    if (w_event == EV_STOP) begin
                        r_dist_tot <= '0;
                        r_ticks    <= '0;
                        r_sum      <= '0;
                        r_count    <= '0;
                        r_peak     <= '0;
                    end
                end
            end
        end else if (i_cmd.sample) begin
            if (r_sv && (r_mode == MODE_RUNNING)) begin
                r_dist_tot <= w_dsum[32] ? '1 : w_dsum[31:0];
                if (r_ticks != '1) begin
                    r_ticks <= r_ticks + 32'd1;
                end
                if (r_speed > r_peak) begin
                    r_peak <= r_speed;
                end
                if ((r_speed > r_min_avg) && (r_count != COUNT_MAX)) begin
                    r_sum   <= r_sum + {24'd0, r_speed};
                    r_count <= r_count + 24'd1;
                end
            end
        end
    end

    // The mean fits in 14 bits, so the top of the sum is already below the count.
    assign w_trial = {r_rem, r_low[13]};
    assign w_diff  = w_trial - {1'b0, r_count};
    assign w_take  = w_trial >= {1'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= StepW'(DivSteps - 1);
        end else if (i_cmd.div_step && (r_dcnt != '0)) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= r_sum[37:14];
            r_low <= r_sum[13:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_take ? w_diff[23:0] : w_trial[23:0];
            r_low <= {r_low[12:0], 1'b0};
            r_quo <= {r_quo[12:0], w_take};
        end
    end

    assign o_status.div_done = (r_dcnt == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_state <= r_mode;
            r_o_event <= r_event;
            r_o_dist  <= r_dist_tot;
            r_o_ticks <= r_ticks;
            r_o_avg   <= (r_count == '0) ? '0 : r_quo;
            r_o_peak  <= r_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ride_state        = r_o_state;
    assign o_event_res         = r_o_event;
    assign o_total_distance_mm = r_o_dist;
    assign o_ride_ticks        = r_o_ticks;
    assign o_average_speed     = r_o_avg;
    assign o_peak_speed        = r_o_peak;

endmodule

// File: rtl/ride_session_tracker.sv
// Top level of the ride session tracker: sequencer plus datapath.
//
//   channel   valid        stall        payload
//   input     i_in_valid   o_in_stall   i_now_ms .. i_speed_centi
//   output    o_out_valid  i_out_stall  o_ride_state .. o_peak_speed
//   config    i_cfg_we     (none)       i_cfg_index, i_cfg_data
//
// Each word passes through capture, touch handling, sample update and divider
// setup, then the one-bit-per-cycle restoring divider for the 14-bit mean,
// and the result load. The result becomes valid after the load, and the next
// word can be accepted in that same cycle. The input stalls while a word is
// in work. A stalled result holds in the output register; the next word may be
// accepted meanwhile and waits in the load state until the register frees.
// Reset is synchronous and restores the sequencer, configuration, ride state,
// statistics and output valid flag at once, but not captured or output data.
module ride_session_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_ms,
    input  logic        i_touch_present,
    input  logic        i_hit_start,
    input  logic        i_hit_continue,
    input  logic        i_hit_stop,
    input  logic        i_sample_valid,
    input  logic [15:0] i_distance_mm,
    input  logic [13:0] i_speed_centi,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_ride_state,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_total_distance_mm,
    output logic [31:0] o_ride_ticks,
    output logic [13:0] o_average_speed,
    output logic [13:0] o_peak_speed
);
    import rst_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rst_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_now_ms            (i_now_ms),
        .i_touch_present     (i_touch_present),
        .i_hit_start         (i_hit_start),
        .i_hit_continue      (i_hit_continue),
        .i_hit_stop          (i_hit_stop),
        .i_sample_valid      (i_sample_valid),
        .i_distance_mm       (i_distance_mm),
        .i_speed_centi       (i_speed_centi),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_ride_state        (o_ride_state),
        .o_event_res         (o_event_res),
        .o_total_distance_mm (o_total_distance_mm),
        .o_ride_ticks        (o_ride_ticks),
        .o_average_speed     (o_average_speed),
        .o_peak_speed        (o_peak_speed)
    );

endmodule

// File: rtl/rst_checker.sv
// Port-level assertions for the ride session tracker and their bind.
module rst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_ride_state,
    input logic [2:0]  o_event_res,
    input logic [31:0] o_total_distance_mm,
    input logic [31:0] o_ride_ticks,
    input logic [13:0] o_peak_speed
);
    import rst_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word accepted while one is in work");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_total_distance_mm)))
        else $error("stalled result changed");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_STOP)) |->
        ((o_ride_state == MODE_STOPPED) && (o_total_distance_mm == '0) &&
         (o_ride_ticks == '0) && (o_peak_speed == '0)))
        else $error("stop word carries stale statistics");

    a_event_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_event_res == EV_NEW) || (o_event_res == EV_RESUME))) |->
        (o_ride_state == MODE_RUNNING))
        else $error("start or resume word not in running state");

endmodule

bind ride_session_tracker rst_checker u_rst_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_stall          (o_in_stall),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_ride_state        (o_ride_state),
    .o_event_res         (o_event_res),
    .o_total_distance_mm (o_total_distance_mm),
    .o_ride_ticks        (o_ride_ticks),
    .o_peak_speed        (o_peak_speed)
);

// File: bench/ride_session_tracker_tb.sv
// Self-checking testbench of the ride session tracker with its own ride predictor.
module ride_session_tracker_tb;
    import rst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 50;

    typedef struct {
        logic [31:0] now_ms;
        logic        touch_present;
        logic        hit_start;
        logic        hit_continue;
        logic        hit_stop;
        logic        sample_valid;
        logic [15:0] distance_mm;
        logic [13:0] speed_centi;
    } t_word;

    typedef struct {
        t_mode       ride_state;
        t_event      event_res;
        logic [31:0] total_distance_mm;
        logic [31:0] ride_ticks;
        logic [13:0] average_speed;
        logic [13:0] peak_speed;
    } t_ride;

    typedef struct {
        t_word w;
        bit    typed;
        t_ride ride;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_now_ms = '0;
    logic        i_touch_present = 1'b0;
    logic        i_hit_start = 1'b0;
    logic        i_hit_continue = 1'b0;
    logic        i_hit_stop = 1'b0;
    logic        i_sample_valid = 1'b0;
    logic [15:0] i_distance_mm = '0;
    logic [13:0] i_speed_centi = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_ride_state;
    logic [2:0]  o_event_res;
    logic [31:0] o_total_distance_mm;
    logic [31:0] o_ride_ticks;
    logic [13:0] o_average_speed;
    logic [13:0] o_peak_speed;

    ride_session_tracker uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_now_ms            (i_now_ms),
        .i_touch_present     (i_touch_present),
        .i_hit_start         (i_hit_start),
        .i_hit_continue      (i_hit_continue),
        .i_hit_stop          (i_hit_stop),
        .i_sample_valid      (i_sample_valid),
        .i_distance_mm       (i_distance_mm),
        .i_speed_centi       (i_speed_centi),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_ride_state        (o_ride_state),
        .o_event_res         (o_event_res),
        .o_total_distance_mm (o_total_distance_mm),
        .o_ride_ticks        (o_ride_ticks),
        .o_average_speed     (o_average_speed),
        .o_peak_speed        (o_peak_speed)
    );

    t_mode       trk_mode = MODE_STOPPED;
    logic [31:0] trk_last_press = '0;
    logic        trk_skip_touch = 1'b0;
    logic [31:0] trk_dist = '0;
    logic [31:0] trk_ticks = '0;
    logic [37:0] trk_sum = '0;
    logic [23:0] trk_count = '0;
    logic [13:0] trk_peak = '0;
    logic [15:0] trk_debounce = DEBOUNCE_RESET;
    logic [13:0] trk_min_avg = MIN_AVG_RESET;

    t_ride       predicted_rides[$];
    t_row        directed_rows[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_pct = 0;
    int          stall_run = 0;
    int          gap_max = 0;
    int          burst_left = 0;
    logic [31:0] stim_now = '0;

    always #1 i_clk = ~i_clk;

    function automatic t_word mk_word(input logic [31:0] now, input bit t, input bit hs,
                                      input bit hc, input bit hp, input bit sv,
                                      input logic [15:0] d, input logic [13:0] s);
        t_word w;
        w.now_ms = now;
        w.touch_present = t;
        w.hit_start = hs;
        w.hit_continue = hc;
        w.hit_stop = hp;
        w.sample_valid = sv;
        w.distance_mm = d;
        w.speed_centi = s;
        return w;
    endfunction

    function automatic t_ride mk_ride(input t_mode m, input t_event e, input logic [31:0] d,
                                      input logic [31:0] t, input logic [13:0] a,
                                      input logic [13:0] p);
        t_ride r;
        r.ride_state = m;
        r.event_res = e;
        r.total_distance_mm = d;
        r.ride_ticks = t;
        r.average_speed = a;
        r.peak_speed = p;
        return r;
    endfunction

    function automatic t_ride predict_ride(input t_word w);
        t_ride       r;
        t_event      ev;
        logic [32:0] dsum;
        ev = EV_NONE;
        if (w.touch_present) begin
            if (!trk_skip_touch) begin
                if ((w.now_ms - trk_last_press) > {16'd0, trk_debounce}) begin
                    if (trk_mode == MODE_PAUSED) begin
                        if (w.hit_continue) begin
                            trk_mode = MODE_RUNNING;
                            ev = EV_RESUME;
                        end else if (w.hit_stop) begin
                            trk_mode = MODE_STOPPED;
                            trk_dist = '0;
                            trk_ticks = '0;
                            trk_sum = '0;
                            trk_count = '0;
                            trk_peak = '0;
                            ev = EV_STOP;
                        end
                    end else if (w.hit_start) begin
                        if (trk_mode == MODE_STOPPED) begin
                            trk_mode = MODE_RUNNING;
                            ev = EV_NEW;
                        end else begin
                            trk_mode = MODE_PAUSED;
                            ev = EV_PAUSE;
                        end
                    end
                    if (ev != EV_NONE) begin
                        trk_last_press = w.now_ms;
                    end
                end
                trk_skip_touch = 1'b1;
            end else begin
                trk_skip_touch = 1'b0;
            end
        end
        if (w.sample_valid && trk_mode == MODE_RUNNING) begin
            dsum = {1'b0, trk_dist} + {17'd0, w.distance_mm};
            trk_dist = dsum[32] ? '1 : dsum[31:0];
            if (trk_ticks != '1) begin
                trk_ticks = trk_ticks + 32'd1;
            end
            if (w.speed_centi > trk_peak) begin
                trk_peak = w.speed_centi;
            end
            if (w.speed_centi > trk_min_avg && trk_count != COUNT_MAX) begin
                trk_sum = trk_sum + {24'd0, w.speed_centi};
                trk_count = trk_count + 24'd1;
            end
        end
        r.ride_state = trk_mode;
        r.event_res = ev;
        r.total_distance_mm = trk_dist;
        r.ride_ticks = trk_ticks;
        r.average_speed = (trk_count != '0) ? 14'(trk_sum / {14'd0, trk_count}) : '0;
        r.peak_speed = trk_peak;
        return r;
    endfunction

    function automatic t_word random_word();
        t_word w;
        int    r;
        w = mk_word('0, 0, 0, 0, 0, 0, '0, '0);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            w.now_ms = $urandom;
            w.touch_present = 1'($urandom_range(0, 1));
            w.hit_start = 1'($urandom_range(0, 1));
            w.hit_continue = 1'($urandom_range(0, 1));
            w.hit_stop = 1'($urandom_range(0, 1));
            w.sample_valid = 1'($urandom_range(0, 1));
            w.distance_mm = 16'($urandom);
            w.speed_centi = 14'($urandom);
            stim_now = w.now_ms;
            return w;
        end
        stim_now = stim_now + $urandom_range(0, 2 * trk_debounce + 4);
        w.now_ms = stim_now;
        r = $urandom_range(0, 99);
        if (trk_skip_touch) begin
            w.touch_present = (r < 60);
            w.hit_start = 1'($urandom_range(0, 1));
            w.hit_continue = 1'($urandom_range(0, 1));
            w.hit_stop = 1'($urandom_range(0, 1));
        end else if (r < 30) begin
            w.touch_present = 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                if (trk_mode != MODE_PAUSED) begin
                    w.hit_start = 1'b1;
                end else if ($urandom_range(0, 9) < 7) begin
                    w.hit_continue = 1'b1;
                end else begin
                    w.hit_stop = 1'b1;
                end
            end else begin
                w.hit_start = 1'($urandom_range(0, 1));
                w.hit_continue = 1'($urandom_range(0, 1));
                w.hit_stop = 1'($urandom_range(0, 1));
            end
        end
        w.sample_valid = ($urandom_range(0, 99) < 75);
        case ($urandom_range(0, 9))
            0: w.distance_mm = '0;
            1: w.distance_mm = '1;
            default: w.distance_mm = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: w.speed_centi = '0;
            1: w.speed_centi = '1;
            2: w.speed_centi = trk_min_avg;
            3: w.speed_centi = trk_min_avg + 14'd1;
            default: w.speed_centi = 14'($urandom);
        endcase
        return w;
    endfunction

    task automatic row_typed(input t_word w, input t_ride r);
        t_row row;
        row.w = w;
        row.typed = 1'b1;
        row.ride = r;
        directed_rows = {directed_rows, row};
    endtask

    task automatic row_pred(input t_word w);
        t_row row;
        row.w = w;
        row.typed = 1'b0;
        row.ride = mk_ride(MODE_STOPPED, EV_NONE, '0, '0, '0, '0);
        directed_rows = {directed_rows, row};
    endtask

    task automatic send_row(input t_row row);
        t_ride pred;
        @(negedge i_clk);
        i_now_ms = row.w.now_ms;
        i_touch_present = row.w.touch_present;
        i_hit_start = row.w.hit_start;
        i_hit_continue = row.w.hit_continue;
        i_hit_stop = row.w.hit_stop;
        i_sample_valid = row.w.sample_valid;
        i_distance_mm = row.w.distance_mm;
        i_speed_centi = row.w.speed_centi;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pred = predict_ride(row.w);
        if (row.typed) begin
            predicted_rides = {predicted_rides, row.ride};
        end else begin
            predicted_rides = {predicted_rides, pred};
        end
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                repeat ($urandom_range(1, gap_max)) begin
                    @(negedge i_clk);
                    i_in_valid = 1'b0;
                end
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (predicted_rides.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        if (idx == CFG_DEBOUNCE) begin
            trk_debounce = data;
        end else begin
            trk_min_avg = data[13:0];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
            stall_run = i_out_stall ? $urandom_range(1, 30) : $urandom_range(1, 20);
        end else begin
            stall_run--;
        end
    end

    always @(posedge i_clk) begin
        t_ride want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_rides.size() == 0) begin
                $display("%0t: result word expected none got ride_state %0d event %0d",
                         $time, o_ride_state, o_event_res);
                mismatches++;
            end else begin
                want = predicted_rides.pop_front();
                check_field("ride_state", 32'(want.ride_state), 32'(o_ride_state));
                check_field("event_res", 32'(want.event_res), 32'(o_event_res));
                check_field("total_distance_mm", want.total_distance_mm, o_total_distance_mm);
                check_field("ride_ticks", want.ride_ticks, o_ride_ticks);
                check_field("average_speed", 32'(want.average_speed), 32'(o_average_speed));
                check_field("peak_speed", 32'(want.peak_speed), 32'(o_peak_speed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [15:0] deb;
        logic [15:0] mav;

        row_typed(mk_word(32'd0, 0, 0, 0, 0, 1, 16'hFFFF, 14'h3FFF),
                  mk_ride(MODE_STOPPED, EV_NONE, 0, 0, 0, 0));
        row_typed(mk_word(32'd100, 1, 1, 0, 0, 0, 0, 0),
                  mk_ride(MODE_STOPPED, EV_NONE, 0, 0, 0, 0));
        row_typed(mk_word(32'd200, 1, 0, 0, 0, 0, 0, 0),
                  mk_ride(MODE_STOPPED, EV_NONE, 0, 0, 0, 0));
        row_typed(mk_word(32'd501, 1, 1, 0, 0, 1, 16'hFFFF, 14'h3FFF),
                  mk_ride(MODE_RUNNING, EV_NEW, 32'd65535, 32'd1, 14'h3FFF, 14'h3FFF));
        row_pred(mk_word(32'd502, 1, 1, 1, 1, 0, 0, 0));
        row_pred(mk_word(32'd600, 0, 0, 0, 0, 1, 0, 0));
        row_pred(mk_word(32'd610, 0, 0, 0, 0, 1, 1, 150));
        row_pred(mk_word(32'd620, 0, 0, 0, 0, 1, 1, 151));
        row_pred(mk_word(32'd1001, 1, 1, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd1001, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd1002, 1, 1, 0, 0, 1, 500, 9000));
        row_pred(mk_word(32'd1003, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd1100, 0, 0, 0, 0, 1, 16'hFFFF, 14'h3FFF));
        row_pred(mk_word(32'd1600, 1, 1, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd1600, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd1601, 1, 0, 1, 1, 1, 1000, 300));
        row_pred(mk_word(32'd1602, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd2200, 1, 0, 1, 1, 0, 0, 0));
        row_pred(mk_word(32'd2201, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd2300, 1, 1, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd2301, 1, 0, 0, 0, 0, 0, 0));
        row_typed(mk_word(32'd2900, 1, 0, 0, 1, 1, 5, 5),
                  mk_ride(MODE_STOPPED, EV_STOP, 0, 0, 0, 0));
        row_pred(mk_word(32'd2901, 1, 0, 0, 0, 0, 0, 0));
        row_pred(mk_word(32'd100, 1, 1, 0, 0, 1, 10, 200));
        row_pred(mk_word(32'hFFFF_FFFF, 1, 1, 1, 1, 1, 0, 14'h3FFF));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        stall_pct = 30;
        gap_max = 6;
        foreach (directed_rows[i]) begin
            pace();
            send_row(directed_rows[i]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    deb = '0;
                    mav = '0;
                end
                1: begin
                    deb = '1;
                    mav = '1;
                end
                3: begin
                    deb = DEBOUNCE_RESET;
                    mav = {2'b00, MIN_AVG_RESET};
                end
                5: begin
                    deb = 16'($urandom);
                    mav = 16'($urandom);
                end
                default: begin
                    deb = 16'($urandom_range(0, 2000));
                    mav = 16'($urandom);
                end
            endcase
            write_reg(CFG_DEBOUNCE, deb);
            write_reg(CFG_MIN_AVG, mav);
            stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(10, 60);
            gap_max = (ph == 0 || ph == 4) ? 0 : $urandom_range(2, 25);
            burst_left = 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                t_row row;
                row.w = random_word();
                row.typed = 1'b0;
                row.ride = mk_ride(MODE_STOPPED, EV_NONE, '0, '0, '0, '0);
                pace();
                send_row(row);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
